// ----- design/bit_vector_rank_store_unit_assert.svh -----
// Assertion macros for the bit vector rank store checks.
`ifndef BIT_VECTOR_RANK_STORE_UNIT_ASSERT_SVH
`define BIT_VECTOR_RANK_STORE_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define BVRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define BVRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bvrs_pkg.sv -----
// Shared types and constants of the bit vector rank store.
`timescale 1ns / 1ps

package bvrs_pkg;

  localparam int unsigned OpWidth   = 3;
  localparam int unsigned PosWidth  = 12;
  localparam int unsigned LenWidth  = 13;
  localparam int unsigned RankWidth = 12;
  localparam int unsigned WordBits  = 64;

  localparam logic [OpWidth-1:0] OP_SET       = 3'd0;
  localparam logic [OpWidth-1:0] OP_CLEAR     = 3'd1;
  localparam logic [OpWidth-1:0] OP_GET       = 3'd2;
  localparam logic [OpWidth-1:0] OP_RANK      = 3'd3;
  localparam logic [OpWidth-1:0] OP_IS_ZERO   = 3'd4;
  localparam logic [OpWidth-1:0] OP_CLEAR_ALL = 3'd5;

  localparam logic [LenWidth-1:0] USED_LENGTH_RESET = 13'd4096;

  typedef struct packed {
    logic [OpWidth-1:0]  operation;
    logic [PosWidth-1:0] position;
  } req_t;

  typedef struct packed {
    logic                 bit_value;
    logic [RankWidth-1:0] rank_count;
    logic                 all_zero;
    logic                 position_error;
  } rsp_t;

  typedef struct packed {
    logic cap;
    logic rd_en;
    logic wr_en;
    logic wr_zero;
    logic cnt_clr;
    logic cnt_word;
    logic cnt_inc;
    logic scan_ld;
    logic acc_en;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic pos_err;
    logic op_single;
    logic op_write;
    logic op_rank;
    logic op_is_zero;
    logic op_clear_all;
    logic len_zero;
    logic scan_last;
    logic sweep_last;
  } status_t;

endpackage

// ----- design/bvrs_datapath.sv -----
// Datapath of the bit vector rank store: word memory, scan counter, popcount and result.
`timescale 1ns / 1ps

module bvrs_datapath import bvrs_pkg::*; #(
  parameter int unsigned STORE_BITS = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [LenWidth-1:0] cfg_wdata_i,
  input  req_t                req_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  output logic                done_o,
  output rsp_t                rsp_o
);

  localparam int unsigned WordCount = (STORE_BITS + WordBits - 1) / WordBits;
  localparam int unsigned AW = (WordCount > 1) ? $clog2(WordCount) : 1;
  localparam int unsigned LenBits = $clog2(STORE_BITS + 1);
  localparam int unsigned LW = (LenBits > LenWidth) ? LenBits : LenWidth;

  function automatic logic [6:0] popcount64(input logic [WordBits-1:0] w);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < WordBits; i++) begin
      n = n + 7'(w[i]);
    end
    return n;
  endfunction

  function automatic logic [WordBits-1:0] low_mask(input logic [5:0] nbits);
    return (64'(1) << nbits) - 64'(1);
  endfunction

  logic [WordBits-1:0] mem [WordCount];

  logic [LenWidth-1:0]  used_length_q;
  req_t                 req_q;
  logic [AW-1:0]        cnt_q, cnt_d;
  logic [AW-1:0]        last_q, last_d;
  logic [WordBits-1:0]  mask_q, mask_d;
  logic [WordBits-1:0]  rdata_q;
  logic                 rvalid_q, rlast_q;
  logic [RankWidth-1:0] acc_cnt_q, acc_cnt_d;
  logic                 acc_nz_q, acc_nz_d;
  logic                 done_q;
  rsp_t                 rsp_q, rsp_d;

  logic [LW-1:0]       pos_ext, used_ext, eff_len;
  logic [LW-7:0]       full_words;
  logic [5:0]          rest_bits, bit_idx;
  logic [AW-1:0]       pos_word;
  logic                pos_err;
  logic [WordBits-1:0] word_masked, wdata;

  assign pos_ext    = LW'(req_q.position);
  assign used_ext   = LW'(used_length_q);
  assign eff_len    = (used_ext > LW'(STORE_BITS)) ? LW'(STORE_BITS) : used_ext;
  assign full_words = eff_len[LW-1:6];
  assign rest_bits  = eff_len[5:0];
  assign bit_idx    = req_q.position[5:0];
  assign pos_word   = AW'(req_q.position >> 6);
  assign pos_err    = (req_q.operation <= OP_RANK) && (pos_ext >= eff_len);

  assign status_o.pos_err      = pos_err;
  assign status_o.op_single    = (req_q.operation == OP_SET) || (req_q.operation == OP_CLEAR) ||
                                 (req_q.operation == OP_GET);
  assign status_o.op_write     = (req_q.operation == OP_SET) || (req_q.operation == OP_CLEAR);
  assign status_o.op_rank      = (req_q.operation == OP_RANK);
  assign status_o.op_is_zero   = (req_q.operation == OP_IS_ZERO);
  assign status_o.op_clear_all = (req_q.operation == OP_CLEAR_ALL);
  assign status_o.len_zero     = (eff_len == '0);
  assign status_o.scan_last    = (cnt_q == last_q);
  assign status_o.sweep_last   = (cnt_q == AW'(WordCount - 1));

  always_comb begin
    priority if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_word) begin
      cnt_d = pos_word;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_comb begin
    priority if (req_q.operation == OP_RANK) begin
      last_d = pos_word;
      mask_d = low_mask(bit_idx);
    end else if (rest_bits != '0) begin
      last_d = AW'(full_words);
      mask_d = low_mask(rest_bits);
    end else begin
      last_d = AW'(full_words - 1'b1);
      mask_d = '1;
    end
  end

  assign word_masked = rlast_q ? (rdata_q & mask_q) : rdata_q;

  always_comb begin
    acc_cnt_d = acc_cnt_q;
    acc_nz_d  = acc_nz_q;
    priority if (cmd_i.scan_ld) begin
      acc_cnt_d = '0;
      acc_nz_d  = 1'b0;
    end else if (cmd_i.acc_en && rvalid_q) begin
      acc_cnt_d = acc_cnt_q + RankWidth'(popcount64(word_masked));
      acc_nz_d  = acc_nz_q | (|word_masked);
    end
  end

  always_comb begin
    if (cmd_i.wr_zero) begin
      wdata = '0;
    end else if (req_q.operation == OP_SET) begin
      wdata = rdata_q | (64'(1) << bit_idx);
    end else begin
      wdata = rdata_q & ~(64'(1) << bit_idx);
    end
  end

  always_comb begin
    rsp_d = '0;
    if (pos_err) begin
      rsp_d.position_error = 1'b1;
    end else if (req_q.operation == OP_GET) begin
      rsp_d.bit_value = rdata_q[bit_idx];
    end else if (req_q.operation == OP_RANK) begin
      rsp_d.rank_count = acc_cnt_q;
    end else if (req_q.operation == OP_IS_ZERO) begin
      rsp_d.all_zero = ~acc_nz_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_length_q <= USED_LENGTH_RESET;
      cnt_q         <= '0;
      rvalid_q      <= 1'b0;
      rlast_q       <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        used_length_q <= cfg_wdata_i;
      end
      cnt_q    <= cnt_d;
      rvalid_q <= cmd_i.rd_en;
      rlast_q  <= cmd_i.rd_en && (cnt_q == last_q);
      done_q   <= cmd_i.res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      req_q <= req_i;
    end
    if (cmd_i.scan_ld) begin
      last_q <= last_d;
      mask_q <= mask_d;
    end
    acc_cnt_q <= acc_cnt_d;
    acc_nz_q  <= acc_nz_d;
    if (cmd_i.res_load) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cnt_q] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[cnt_q];
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ----- design/bvrs_controller.sv -----
// Controller state machine of the bit vector rank store.
`timescale 1ns / 1ps

module bvrs_controller import bvrs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output logic    busy_o,
  output cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_READ     = 3'd2;
  localparam logic [2:0] ST_MODIFY   = 3'd3;
  localparam logic [2:0] ST_SCAN     = 3'd4;
  localparam logic [2:0] ST_DRAIN    = 3'd5;
  localparam logic [2:0] ST_FINISH   = 3'd6;
  localparam logic [2:0] ST_SWEEP    = 3'd7;

  logic [2:0] state_q, state_d;
  logic       reply_q, reply_d;

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    reply_d = reply_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.cap = 1'b1;
          state_d   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        priority if (status_i.pos_err) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end else if (status_i.op_single) begin
          cmd_o.cnt_word = 1'b1;
          state_d        = ST_READ;
        end else if (status_i.op_rank) begin
          cmd_o.cnt_clr = 1'b1;
          cmd_o.scan_ld = 1'b1;
          state_d       = ST_SCAN;
        end else if (status_i.op_is_zero) begin
          cmd_o.cnt_clr = 1'b1;
          cmd_o.scan_ld = 1'b1;
          state_d       = status_i.len_zero ? ST_FINISH : ST_SCAN;
        end else if (status_i.op_clear_all) begin
          cmd_o.cnt_clr = 1'b1;
          reply_d       = 1'b1;
          state_d       = ST_SWEEP;
        end else begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_MODIFY;
      end
      ST_MODIFY: begin
        cmd_o.wr_en    = status_i.op_write;
        cmd_o.res_load = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.acc_en = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_DRAIN: begin
        cmd_o.acc_en = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.res_load = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_SWEEP: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_zero = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (status_i.sweep_last) begin
          cmd_o.res_load = reply_q;
          reply_d        = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      reply_q <= 1'b0;
    end else begin
      state_q <= state_d;
      reply_q <= reply_d;
    end
  end

endmodule

// ----- design/bit_vector_rank_store_unit.sv -----
// Top level of the bit vector rank store: controller and datapath.
//
// A request (operation, position) is taken at a rising edge with start_i high
// and busy_o low. Exactly one response follows, shown on rsp_o for a single
// cycle while done_o is high; the receiver cannot stall it, so it must take
// the response in that cycle. busy_o drops in the cycle done_o rises, so the
// next request can be taken while the response is shown.
// Set, clear and get first read the word of the position; set and clear
// write it back. Position errors and unused codes are answered at
// dispatch. Rank at p scans the words up to the word of p; is_zero scans
// the used words (none at zero length); clear_all zeroes every word.
// Rank and is_zero read one 64-bit word per cycle through the single memory
// port and popcount it.
// After reset a clearing pass writes zero to every word, one word per cycle;
// busy_o is high during it.
// cfg_we_i writes used_length at any edge; write it only while idle.
`timescale 1ns / 1ps

module bit_vector_rank_store_unit import bvrs_pkg::*; #(
  parameter int unsigned STORE_BITS = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  req_t                req_i,
  output logic                done_o,
  output rsp_t                rsp_o,
  input  logic                cfg_we_i,
  input  logic [LenWidth-1:0] cfg_wdata_i
);

  cmd_t    cmd;
  status_t status;

  bvrs_controller u_controller (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .busy_o   (busy_o),
    .cmd_o    (cmd)
  );

  bvrs_datapath #(
    .STORE_BITS (STORE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

endmodule

// ----- design/bvrs_checker.sv -----
// Port-level assertion checker of the bit vector rank store, bound to the top level.
`timescale 1ns / 1ps
`include "bit_vector_rank_store_unit_assert.svh"

module bvrs_assert_checker import bvrs_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input rsp_t rsp_o
);

  logic err_shown;
  logic rsp_data_zero;

  assign err_shown     = done_o && rsp_o.position_error;
  assign rsp_data_zero = !rsp_o.bit_value && (rsp_o.rank_count == '0) && !rsp_o.all_zero;

  `BVRS_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "accepted request not busy")
  `BVRS_ASSERT_NEXT(a_done_single, done_o, !done_o, "response strobe longer than one cycle")
  `BVRS_ASSERT(a_done_idle, !done_o || !busy_o, "response shown while busy")
  `BVRS_ASSERT(a_error_clean, !err_shown || rsp_data_zero, "error response carries data")

endmodule

bind bit_vector_rank_store_unit bvrs_assert_checker u_bvrs_assert_checker (.*);

// ----- sim/bvrs_checker.sv -----
// Response checker for the bit vector rank store: predicts each response and compares it.
`timescale 1ns / 1ps

module bvrs_checker import bvrs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  req_t                req_i,
  input  logic                done_i,
  input  rsp_t                rsp_i,
  input  logic                cfg_we_i,
  input  logic [LenWidth-1:0] cfg_wdata_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  checked_o
);

  localparam int unsigned StoreBits = 4096;
  localparam int unsigned WordCount = (StoreBits + WordBits - 1) / WordBits;

  logic [WordBits-1:0] bit_mem [WordCount];
  logic [LenWidth-1:0] length_q;
  rsp_t                answer_q [$];
  int                  mismatch_count;
  int                  checked_count;

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t ns: mismatch in %s, expected %0d, got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  function automatic rsp_t store_response(input req_t r);
    rsp_t                a;
    logic [LenWidth-1:0] eff;
    int unsigned         word_i;
    int unsigned         bit_i;
    int unsigned         ones;
    int unsigned         w;
    int unsigned         p;
    a = '0;
    eff = (length_q > LenWidth'(StoreBits)) ? LenWidth'(StoreBits) : length_q;
    if (r.operation <= OP_RANK) begin
      if ({1'b0, r.position} >= eff) begin
        a.position_error = 1'b1;
      end else begin
        word_i = r.position / WordBits;
        bit_i  = r.position % WordBits;
        case (r.operation)
          OP_SET: begin
            bit_mem[word_i][bit_i] = 1'b1;
          end
          OP_CLEAR: begin
            bit_mem[word_i][bit_i] = 1'b0;
          end
          OP_GET: begin
            a.bit_value = bit_mem[word_i][bit_i];
          end
          default: begin
            ones = 0;
            for (w = 0; w < word_i; w++) ones += $countones(bit_mem[w]);
            for (p = 0; p < bit_i; p++) ones += bit_mem[word_i][p];
            a.rank_count = ones[RankWidth-1:0];
          end
        endcase
      end
    end else if (r.operation == OP_IS_ZERO) begin
      a.all_zero = 1'b1;
      for (p = 0; p < eff; p++) begin
        if (bit_mem[p / WordBits][p % WordBits]) a.all_zero = 1'b0;
      end
    end else if (r.operation == OP_CLEAR_ALL) begin
      for (w = 0; w < WordCount; w++) bit_mem[w] = '0;
    end
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int w = 0; w < WordCount; w++) bit_mem[w] = '0;
      length_q = USED_LENGTH_RESET;
      answer_q.delete();
      mismatch_count = 0;
      checked_count = 0;
      errors_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (done_i) begin
        if (answer_q.size() == 0) begin
          report_mismatch("responses outstanding", 0, 1);
        end else begin
          want = answer_q.pop_front();
          checked_count++;
          if (rsp_i.bit_value !== want.bit_value)
            report_mismatch("bit_value", want.bit_value, rsp_i.bit_value);
          if (rsp_i.rank_count !== want.rank_count)
            report_mismatch("rank_count", want.rank_count, rsp_i.rank_count);
          if (rsp_i.all_zero !== want.all_zero)
            report_mismatch("all_zero", want.all_zero, rsp_i.all_zero);
          if (rsp_i.position_error !== want.position_error)
            report_mismatch("position_error", want.position_error, rsp_i.position_error);
        end
      end
      if (start_i && !busy_i) answer_q.push_back(store_response(req_i));
      if (cfg_we_i) length_q = cfg_wdata_i;
      errors_o <= mismatch_count;
      pending_o <= answer_q.size();
      checked_o <= checked_count;
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Top of the bit vector rank store testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import bvrs_pkg::*;

  localparam logic [OpWidth-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OpWidth-1:0] OP_SPARE_B = 3'd7;
  localparam int unsigned StoreBits   = 4096;
  localparam int          PhaseCount  = 14;
  localparam int          PhaseItems  = 100;
  localparam int          StallLimit  = 3000;
  localparam int          DrainCycles = 80;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  req_t                req_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [LenWidth-1:0] cfg_wdata_i = '0;
  logic                busy_o;
  logic                done_o;
  rsp_t                rsp_o;

  int                  errors;
  int                  pending;
  int                  checked;
  int                  sent = 0;
  int                  length_writes = 0;
  int                  stall_cycles = 0;
  logic [LenWidth-1:0] cur_len = USED_LENGTH_RESET;
  bit                  steady = 1'b0;

  bit_vector_rank_store_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  bvrs_checker rsp_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .req_i       (req_i),
    .done_i      (done_o),
    .rsp_i       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("%0t ns: no progress for %0d cycles", $time, StallLimit);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic issue(input logic [OpWidth-1:0] op, input logic [PosWidth-1:0] pos);
    if (!steady && $urandom_range(0, 99) < 35) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= req_t'{operation: op, position: pos};
    do @(posedge clk_i); while (busy_o);
    sent++;
  endtask

  task automatic set_length(input logic [LenWidth-1:0] len);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy_o) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_len = len;
    length_writes++;
  endtask

  function automatic logic [PosWidth-1:0] near_position(input logic [LenWidth-1:0] eff);
    int mode;
    int unsigned span;
    mode = $urandom_range(0, 9);
    span = (eff > 128) ? 128 : eff;
    if (eff == 0 || mode == 0) return PosWidth'($urandom_range(0, StoreBits - 1));
    if (mode <= 4) return PosWidth'($urandom_range(0, eff - 1));
    if (mode <= 7) return PosWidth'($urandom_range(0, span - 1));
    return PosWidth'($urandom_range(eff - span, eff - 1));
  endfunction

  function automatic logic [LenWidth-1:0] phase_length(input int ph);
    case (ph)
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd63;
      3: return 13'd64;
      4: return 13'd65;
      5: return 13'd4095;
      6: return 13'd8191;
      7: return 13'd4096;
      8: return LenWidth'($urandom_range(StoreBits + 1, 8191));
      default: return LenWidth'($urandom_range(2, StoreBits - 2));
    endcase
  endfunction

  task automatic random_request();
    int                  roll;
    logic [LenWidth-1:0] eff;
    logic [OpWidth-1:0]  op;
    logic [PosWidth-1:0] pos;
    eff = (cur_len > LenWidth'(StoreBits)) ? LenWidth'(StoreBits) : cur_len;
    roll = $urandom_range(0, 99);
    pos = near_position(eff);
    if (roll < 28) begin
      op = OP_SET;
    end else if (roll < 42) begin
      op = OP_CLEAR;
    end else if (roll < 60) begin
      op = OP_GET;
    end else if (roll < 75) begin
      op = OP_RANK;
    end else if (roll < 86) begin
      op = OP_IS_ZERO;
    end else if (roll < 88) begin
      op = OP_CLEAR_ALL;
    end else if (roll < 91) begin
      op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
    end else begin
      case ($urandom_range(0, 3))
        0: op = OP_SET;
        1: op = OP_CLEAR;
        2: op = OP_GET;
        default: op = OP_RANK;
      endcase
      if (eff < StoreBits) pos = PosWidth'($urandom_range(eff, StoreBits - 1));
    end
    issue(op, pos);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    issue(OP_IS_ZERO, 12'd0);
    issue(OP_SET, 12'd0);
    issue(OP_SET, 12'd4095);
    issue(OP_SET, 12'd63);
    issue(OP_SET, 12'd64);
    issue(OP_GET, 12'd0);
    issue(OP_GET, 12'd1);
    issue(OP_GET, 12'd4095);
    issue(OP_RANK, 12'd0);
    issue(OP_RANK, 12'd64);
    issue(OP_RANK, 12'd65);
    issue(OP_RANK, 12'd4095);
    issue(OP_IS_ZERO, 12'd4095);
    issue(OP_CLEAR, 12'd63);
    issue(OP_GET, 12'd63);
    issue(OP_RANK, 12'd4095);
    issue(OP_SPARE_A, 12'd4095);
    issue(OP_SPARE_B, 12'd0);
    issue(OP_CLEAR_ALL, 12'd2730);
    issue(OP_IS_ZERO, 12'd1365);
    issue(OP_GET, 12'd4095);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      set_length(phase_length(ph));
      steady = (ph == 4 || ph == 10);
      for (int n = 0; n < PhaseItems; n++) random_request();
    end
    steady = 1'b0;

    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d requests and %0d checked responses", sent, checked);
    $display("over %0d length settings, from zero up to beyond the store size", length_writes);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
